@@ design/rsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants for the RSI smoothing block
// Field widths, divider geometry, controller states and the command/status
// records that pass between controller and datapath.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // Field widths
  localparam int PRICE_W  = 32;
  localparam int AVG_W    = 48;
  localparam int PERIOD_W = 8;
  localparam int RSI_W    = 23;
  localparam int FRAC_W   = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
  // 100 in Q7.16
  localparam logic [RSI_W-1:0]    RSI_FULL     = 23'd6553600;

  // Shared divider geometry
  localparam int DIVD_W = 64;          // dividend / quotient shift register
  localparam int DIVS_W = AVG_W + 1;   // divisor (gain + loss carries one bit)
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] STEPS_AVG = 7'd64;
  localparam logic [STEP_W-1:0] STEPS_RSI = 7'd23;

  // Numerator of the ratio: gain times 100 in Q7.16
  localparam int NUM_W = AVG_W + RSI_W;

  // Product width for average times (period - 1)
  localparam int MUL_W = AVG_W + PERIOD_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD_G,
    ST_WAIT_G,
    ST_LOAD_L,
    ST_WAIT_L,
    ST_PREP_R,
    ST_LOAD_R,
    ST_WAIT_R,
    ST_FINISH
  } rsi_state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_FULL,
    RES_DIV
  } rsi_res_t;

  typedef enum logic [1:0] {
    DIV_GAIN,
    DIV_LOSS,
    DIV_RSI
  } rsi_div_sel_t;

  typedef struct packed {
    logic         accept;
    logic         prep;
    logic         div_start;
    rsi_div_sel_t div_sel;
    logic         smooth;
    logic         gain_wr;
    logic         loss_wr;
    logic         num_load;
    logic         out_load;
    rsi_res_t     res_sel;
    logic         res_ready;
  } rsi_cmd_t;

  typedef struct packed {
    logic warm_end;
    logic smooth;
    logic loss_zero;
    logic div_busy;
    logic div_done;
  } rsi_stat_t;

endpackage

@@ design/rsi_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_in_if: price sample channel
// Valid/ready channel carrying one price sample and its series start flag.
// ----------------------------------------------------------------------------
interface rsi_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] price;
  logic        series_start;

  modport source (output valid, output price, output series_start, input ready);
  modport sink   (input valid, input price, input series_start, output ready);
endinterface

@@ design/rsi_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_out_if: RSI result channel
// Valid/ready channel carrying the RSI value and its ready flag.
// ----------------------------------------------------------------------------
interface rsi_out_if;
  logic        valid;
  logic        ready;
  logic [22:0] rsi_value;
  logic        rsi_ready;

  modport source (output valid, output rsi_value, output rsi_ready, input ready);
  modport sink   (input valid, input rsi_value, input rsi_ready, output ready);
endinterface

@@ design/rsi_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_div: shared radix-2 restoring divider
// One quotient bit per cycle. The dividend bits are shifted out of the top
// of the quotient register while quotient bits enter at the bottom.
// ----------------------------------------------------------------------------
module rsi_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rsi_pkg::DIVS_W-1:0]  rem_init,
  input  logic [rsi_pkg::DIVD_W-1:0]  quo_init,
  input  logic [rsi_pkg::DIVS_W-1:0]  divisor,
  input  logic [rsi_pkg::STEP_W-1:0]  steps,
  output logic [rsi_pkg::DIVD_W-1:0]  quo,
  output logic                        busy,
  output logic                        done
);
  import rsi_pkg::*;

  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;

  // Trial subtract of the shifted remainder
  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  // Load, step, finish
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = rem_init;
      quo_nxt  = quo_init;
      dvs_nxt  = divisor;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (diff[DIVS_W]) begin
        rem_nxt = trial[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quo  = quo_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

@@ design/rsi_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_dp: RSI datapath
// Holds the period register, previous price, gain and loss averages and
// sample count; forms the dividends for the shared divider and the result.
// ----------------------------------------------------------------------------
module rsi_dp #(
  parameter int MAX_PERIOD = 255
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rsi_pkg::PERIOD_W-1:0]  cfg_wdata,
  input  logic [rsi_pkg::PRICE_W-1:0]   in_price,
  input  logic                          in_series_start,
  input  rsi_pkg::rsi_cmd_t             cmd,
  output rsi_pkg::rsi_stat_t            stat,
  output logic [rsi_pkg::RSI_W-1:0]     out_rsi_value,
  output logic                          out_rsi_ready
);
  import rsi_pkg::*;

  localparam int CNT_W = $clog2(MAX_PERIOD + 2);
  localparam int CMP_W = ((CNT_W > PERIOD_W) ? CNT_W : PERIOD_W) + 1;

  // Architectural state
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PRICE_W-1:0]  last_price_r, last_price_nxt;
  logic [AVG_W-1:0]    gain_r, gain_nxt;
  logic [AVG_W-1:0]    loss_r, loss_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  // Per-item working registers
  logic [PRICE_W-1:0]  up_r, up_nxt;
  logic [PRICE_W-1:0]  dn_r, dn_nxt;
  logic [MUL_W-1:0]    mul_g_r, mul_g_nxt;
  logic [MUL_W-1:0]    mul_l_r, mul_l_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [DIVS_W-1:0]   den_r, den_nxt;
  logic [RSI_W-1:0]    rsi_value_r, rsi_value_nxt;
  logic                rsi_ready_r, rsi_ready_nxt;

  logic [PERIOD_W-1:0] p_eff;
  logic [PERIOD_W-1:0] p_m1;
  logic [CMP_W-1:0]    n_ext, p_ext, n_inc, n_lim;
  logic                warm;
  logic [PRICE_W-1:0]  prev_price;

  logic [DIVS_W-1:0]   div_rem_init;
  logic [DIVD_W-1:0]   div_quo_init;
  logic [DIVS_W-1:0]   div_divisor;
  logic [STEP_W-1:0]   div_steps;
  logic [DIVD_W-1:0]   div_quo;
  logic                div_busy;
  logic                div_done;

  // Clamp the period to 1..MAX_PERIOD
  always_comb begin
    p_eff = period_r;
    if (period_r == '0) begin
      p_eff = PERIOD_W'(1);
    end else if (32'(period_r) > MAX_PERIOD) begin
      p_eff = PERIOD_W'(MAX_PERIOD);
    end
  end
  assign p_m1 = p_eff - 1'b1;

  // Phase of the series from the stored count
  assign n_ext = CMP_W'(count_r);
  assign p_ext = CMP_W'(p_eff);
  assign n_inc = n_ext + 1'b1;
  assign n_lim = p_ext + 1'b1;
  assign warm  = (n_ext != '0) && (n_ext <= p_ext);

  assign stat.warm_end  = (n_ext == p_ext);
  assign stat.smooth    = (n_ext > p_ext);
  assign stat.loss_zero = (loss_r == '0);
  assign stat.div_busy  = div_busy;
  assign stat.div_done  = div_done;

  // A series start makes the previous price zero
  assign prev_price = in_series_start ? '0 : last_price_r;

  // Divider operands
  always_comb begin
    div_rem_init = '0;
    div_quo_init = '0;
    div_divisor  = DIVS_W'(p_eff);
    div_steps    = STEPS_AVG;
    case (cmd.div_sel)
      DIV_GAIN: begin
        if (cmd.smooth) begin
          div_quo_init = DIVD_W'(mul_g_r) + DIVD_W'({up_r, {FRAC_W{1'b0}}});
        end else begin
          div_quo_init = {gain_r, {FRAC_W{1'b0}}};
        end
      end
      DIV_LOSS: begin
        if (cmd.smooth) begin
          div_quo_init = DIVD_W'(mul_l_r) + DIVD_W'({dn_r, {FRAC_W{1'b0}}});
        end else begin
          div_quo_init = {loss_r, {FRAC_W{1'b0}}};
        end
      end
      DIV_RSI: begin
        div_rem_init = DIVS_W'(num_r[NUM_W-1:RSI_W]);
        div_quo_init = {num_r[RSI_W-1:0], {(DIVD_W-RSI_W){1'b0}}};
        div_divisor  = den_r;
        div_steps    = STEPS_RSI;
      end
      default: begin
      end
    endcase
  end

  rsi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .rem_init (div_rem_init),
    .quo_init (div_quo_init),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quo      (div_quo),
    .busy     (div_busy),
    .done     (div_done)
  );

  // Next-state of all datapath registers
  always_comb begin
    period_nxt     = cfg_we ? cfg_wdata : period_r;
    last_price_nxt = last_price_r;
    gain_nxt       = gain_r;
    loss_nxt       = loss_r;
    count_nxt      = count_r;
    up_nxt         = up_r;
    dn_nxt         = dn_r;
    mul_g_nxt      = mul_g_r;
    mul_l_nxt      = mul_l_r;
    num_nxt        = num_r;
    den_nxt        = den_r;
    rsi_value_nxt  = rsi_value_r;
    rsi_ready_nxt  = rsi_ready_r;

    // Take the beat: form the price change, clear on a series start
    if (cmd.accept) begin
      up_nxt         = (in_price > prev_price) ? in_price - prev_price : '0;
      dn_nxt         = (in_price < prev_price) ? prev_price - in_price : '0;
      last_price_nxt = in_price;
      if (in_series_start) begin
        gain_nxt  = '0;
        loss_nxt  = '0;
        count_nxt = '0;
      end
    end

    // Accumulate during warm-up, scale for smoothing, advance the count
    if (cmd.prep) begin
      if (warm) begin
        gain_nxt = gain_r + AVG_W'(up_r);
        loss_nxt = loss_r + AVG_W'(dn_r);
      end
      mul_g_nxt = MUL_W'(gain_r) * MUL_W'(p_m1);
      mul_l_nxt = MUL_W'(loss_r) * MUL_W'(p_m1);
      count_nxt = (n_inc > n_lim) ? CNT_W'(n_lim) : CNT_W'(n_inc);
    end

    if (cmd.gain_wr) begin
      gain_nxt = div_quo[AVG_W-1:0];
    end
    if (cmd.loss_wr) begin
      loss_nxt = div_quo[AVG_W-1:0];
    end

    // Gain times 100 in Q7.16 is (g << 22) + (g << 21) + (g << 18)
    if (cmd.num_load) begin
      num_nxt = (NUM_W'(gain_r) << 22) + (NUM_W'(gain_r) << 21) + (NUM_W'(gain_r) << 18);
      den_nxt = DIVS_W'(gain_r) + DIVS_W'(loss_r);
    end

    if (cmd.out_load) begin
      rsi_ready_nxt = cmd.res_ready;
      case (cmd.res_sel)
        RES_ZERO: rsi_value_nxt = '0;
        RES_FULL: rsi_value_nxt = RSI_FULL;
        RES_DIV:  rsi_value_nxt = div_quo[RSI_W-1:0];
        default:  rsi_value_nxt = '0;
      endcase
    end
  end

  // Series state and period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= PERIOD_RESET;
      last_price_r <= '0;
      gain_r       <= '0;
      loss_r       <= '0;
      count_r      <= '0;
    end else begin
      period_r     <= period_nxt;
      last_price_r <= last_price_nxt;
      gain_r       <= gain_nxt;
      loss_r       <= loss_nxt;
      count_r      <= count_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    up_r        <= up_nxt;
    dn_r        <= dn_nxt;
    mul_g_r     <= mul_g_nxt;
    mul_l_r     <= mul_l_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    rsi_value_r <= rsi_value_nxt;
    rsi_ready_r <= rsi_ready_nxt;
  end

  assign out_rsi_value = rsi_value_r;
  assign out_rsi_ready = rsi_ready_r;

endmodule

@@ design/rsi_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_ctrl: RSI sequencer
// Steps one sample through accumulate or smooth, then from warm-up end the two
// average divisions and, if loss is nonzero, the ratio; owns in_ready/out_valid.
// ----------------------------------------------------------------------------
module rsi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rsi_pkg::rsi_stat_t  stat,
  output rsi_pkg::rsi_cmd_t   cmd
);
  import rsi_pkg::*;

  rsi_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       smooth_r, smooth_nxt;
  logic       ready_r, ready_nxt;
  rsi_res_t   res_sel_r, res_sel_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = (stat.warm_end || stat.smooth) ? ST_LOAD_G : ST_FINISH;
      ST_LOAD_G: state_nxt = ST_WAIT_G;
      ST_WAIT_G: if (stat.div_done) state_nxt = ST_LOAD_L;
      ST_LOAD_L: state_nxt = ST_WAIT_L;
      ST_WAIT_L: if (stat.div_done) state_nxt = ST_PREP_R;
      ST_PREP_R: state_nxt = stat.loss_zero ? ST_FINISH : ST_LOAD_R;
      ST_LOAD_R: state_nxt = ST_WAIT_R;
      ST_WAIT_R: if (stat.div_done) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Commands and per-item flags
  always_comb begin
    cmd           = '0;
    cmd.smooth    = smooth_r;
    cmd.res_sel   = res_sel_r;
    cmd.res_ready = ready_r;
    cmd.div_sel   = DIV_GAIN;
    smooth_nxt    = smooth_r;
    ready_nxt     = ready_r;
    res_sel_nxt   = res_sel_r;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = in_valid;
      end
      ST_PREP: begin
        cmd.prep    = 1'b1;
        smooth_nxt  = stat.smooth;
        ready_nxt   = stat.warm_end || stat.smooth;
        res_sel_nxt = RES_ZERO;
      end
      ST_LOAD_G: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_GAIN;
      end
      ST_WAIT_G: begin
        cmd.gain_wr = stat.div_done;
      end
      ST_LOAD_L: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_LOSS;
      end
      ST_WAIT_L: begin
        cmd.loss_wr = stat.div_done;
      end
      ST_PREP_R: begin
        cmd.num_load = 1'b1;
        res_sel_nxt  = stat.loss_zero ? RES_FULL : RES_DIV;
      end
      ST_LOAD_R: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RSI;
      end
      ST_WAIT_R: begin
        cmd.div_sel = DIV_RSI;
      end
      ST_FINISH: begin
        cmd.out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  // Output beat: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      smooth_r    <= 1'b0;
      ready_r     <= 1'b0;
      res_sel_r   <= RES_ZERO;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      smooth_r    <= smooth_nxt;
      ready_r     <= ready_nxt;
      res_sel_r   <= res_sel_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // An accepted beat always moves straight into preparation
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_PREP))
    else $error("accepted beat did not enter preparation");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");

  // Start the divider only when it is free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  // A finished division is only seen while waiting for it
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> (state_r == ST_WAIT_G || state_r == ST_WAIT_L ||
                       state_r == ST_WAIT_R))
    else $error("divider finished outside a wait state");
`endif

endmodule

@@ design/rsi_wilder_smoothing_top.sv @@
`timescale 1ns / 1ps
// During warm-up the result bypasses the divider; from warm-up end it waits on the
// shared one-bit-per-cycle divider (64 + 64 steps, plus 23 if the loss is nonzero).
// Throughput: one sample at a time; the next beat is taken when the previous one
// has left the datapath, even while its result still waits in the output register.
// Reset: synchronous active-low rst_n clears the series state, sets the period to 14.
// ----------------------------------------------------------------------------
// rsi_wilder_smoothing_top: streaming RSI with Wilder smoothing
// Controller sequences the datapath and its shared divider; one result beat
// per price beat.
// ----------------------------------------------------------------------------
module rsi_wilder_smoothing_top #(
  parameter int MAX_PERIOD = 255
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rsi_in_if.sink                        in_ch,
  rsi_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [rsi_pkg::PERIOD_W-1:0]  cfg_wdata
);
  import rsi_pkg::*;

  rsi_cmd_t  cmd;
  rsi_stat_t stat;
  logic      in_ready;
  logic      out_valid;

  rsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rsi_dp #(
    .MAX_PERIOD (MAX_PERIOD)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_price        (in_ch.price),
    .in_series_start (in_ch.series_start),
    .cmd             (cmd),
    .stat            (stat),
    .out_rsi_value   (out_ch.rsi_value),
    .out_rsi_ready   (out_ch.rsi_ready)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
